[src/imd_pkg.sv]
package imd_pkg;

  localparam int AXIS_W   = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 32;
  localparam int MAG_MAX  = 56755;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;

  localparam logic [CNT_W-1:0] SQUARE_LAST = 4'd5;
  localparam logic [CNT_W-1:0] STEP_LAST   = 4'd15;

  localparam logic [15:0] MARGIN_RESET = 16'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_ACC_BASELINE  = 3'd0,
    REG_GYRO_BASELINE = 3'd1,
    REG_ACC_MARGIN    = 3'd2,
    REG_GYRO_MARGIN   = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] rate_x;
    logic signed [AXIS_W-1:0] rate_y;
    logic signed [AXIS_W-1:0] rate_z;
  } in_t;

  typedef struct packed {
    logic             moving;
    logic [MAG_W-1:0] accel_mean;
    logic [MAG_W-1:0] rate_mean;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_UPDATE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       square;
    logic [2:0] axis;
    logic       root;
    logic       update;
    logic       divide;
    logic       finish;
  } cmd_t;

endpackage

[src/imu_motion_detector.sv]
// Each request runs through these steps in order: an idle step that takes it,
// 6 squarings on the shared squaring multiplier, 16 bit-serial square root steps,
// one window update, one reciprocal-multiply divide and a final load of the result.
// A new request is taken only after the previous result has been loaded.
// The next request is taken while a finished result waits on a stalled output.
// Reset (rst, synchronous): windows read as zero, sums and position cleared,
// baselines 0, margins 20; the window memory needs no clearing pass.
module imu_motion_detector #(
  parameter int WINDOW = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  imd_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output imd_pkg::out_t             out_data,
  input  logic                      wr_en,
  input  logic [imd_pkg::IDX_W-1:0] wr_index,
  input  logic [15:0]               wr_data
);
  import imd_pkg::*;

  cmd_t cmd;

  imd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  imd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .out_data (out_data)
  );

endmodule

[src/imd_ctrl.sv]
module imd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output imd_pkg::cmd_t cmd
);
  import imd_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid & out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        cmd.axis   = cnt[2:0];
        if (cnt == SQUARE_LAST) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (cnt == STEP_LAST) begin
          cnt_next   = '0;
          state_next = S_UPDATE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

[src/imd_datapath.sv]
module imd_datapath #(
  parameter int WINDOW = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  imd_pkg::cmd_t               cmd,
  input  imd_pkg::in_t                in_data,
  input  logic                        wr_en,
  input  logic [imd_pkg::IDX_W-1:0]   wr_index,
  input  logic [15:0]                 wr_data,
  output imd_pkg::out_t               out_data
);
  import imd_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * MAG_MAX + 1);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

  function automatic logic [MAG_W+16:0] sqrt_step(
    input logic [MAG_W:0]   rem,
    input logic [MAG_W-1:0] root,
    input logic [1:0]       pair
  );
    logic [MAG_W+2:0] cur;
    logic [MAG_W+2:0] trial;
    cur   = {rem, pair};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      sqrt_step = {(MAG_W+1)'(cur - trial), root[MAG_W-2:0], 1'b1};
    end else begin
      sqrt_step = {cur[MAG_W:0], root[MAG_W-2:0], 1'b0};
    end
  endfunction

  in_t                     in_reg;
  logic signed [AXIS_W-1:0] axis_val;
  logic [AXIS_W-1:0]       axis_mag;
  logic [SQ_W-1:0]         product;
  logic [SQ_W-1:0]         acc_sq, rate_sq;
  logic [MAG_W:0]          a_rem, r_rem;
  logic [MAG_W-1:0]        a_root, r_root;
  logic [MAG_W+16:0]       a_step, r_step;

  logic [2*MAG_W-1:0]      mem [WINDOW];
  logic [2*MAG_W-1:0]      rd_data;
  logic [WINDOW-1:0]       win_valid;
  logic [POS_W-1:0]        pos;
  logic [MAG_W-1:0]        a_old, r_old;
  logic [SUM_W-1:0]        a_sum, r_sum, a_sum_next, r_sum_next;
  logic [PROD_W-1:0]       a_prod, r_prod;
  logic [MAG_W-1:0]        a_q, r_q;

  logic [15:0]             acc_baseline, gyro_baseline, acc_margin, gyro_margin;
  logic [16:0]             acc_limit, gyro_limit;

  always_comb begin
    case (cmd.axis)
      3'd0:    axis_val = in_reg.accel_x;
      3'd1:    axis_val = in_reg.accel_y;
      3'd2:    axis_val = in_reg.accel_z;
      3'd3:    axis_val = in_reg.rate_x;
      3'd4:    axis_val = in_reg.rate_y;
      default: axis_val = in_reg.rate_z;
    endcase
  end

  // full-scale negative maps to 0x8000, which is correct as unsigned
  assign axis_mag = axis_val[AXIS_W-1] ? AXIS_W'(-axis_val) : axis_val;
  assign product  = SQ_W'(axis_mag) * SQ_W'(axis_mag);

  assign a_step = sqrt_step(a_rem, a_root, acc_sq[SQ_W-1 -: 2]);
  assign r_step = sqrt_step(r_rem, r_root, rate_sq[SQ_W-1 -: 2]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_reg  <= in_data;
      acc_sq  <= '0;
      rate_sq <= '0;
      a_rem   <= '0;
      r_rem   <= '0;
      a_root  <= '0;
      r_root  <= '0;
    end else if (cmd.square) begin
      if (cmd.axis < 3'd3) begin
        acc_sq <= acc_sq + product;
      end else begin
        rate_sq <= rate_sq + product;
      end
    end else if (cmd.root) begin
      // consume the radicand two bits at a time from the top
      acc_sq  <= {acc_sq[SQ_W-3:0], 2'b00};
      rate_sq <= {rate_sq[SQ_W-3:0], 2'b00};
      a_rem   <= a_step[MAG_W+16 -: MAG_W+1];
      a_root  <= a_step[MAG_W-1:0];
      r_rem   <= r_step[MAG_W+16 -: MAG_W+1];
      r_root  <= r_step[MAG_W-1:0];
    end
  end

  // window store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[pos] <= {a_root, r_root};
    end
    rd_data <= mem[pos];
  end

  assign a_old      = win_valid[pos] ? rd_data[2*MAG_W-1:MAG_W] : '0;
  assign r_old      = win_valid[pos] ? rd_data[MAG_W-1:0] : '0;
  assign a_sum_next = a_sum - SUM_W'(a_old) + SUM_W'(a_root);
  assign r_sum_next = r_sum - SUM_W'(r_old) + SUM_W'(r_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      pos       <= '0;
      a_sum     <= '0;
      r_sum     <= '0;
    end else if (cmd.update) begin
      win_valid[pos] <= 1'b1;
      pos            <= (pos == POS_LAST) ? '0 : pos + 1'b1;
      a_sum          <= a_sum_next;
      r_sum          <= r_sum_next;
    end
  end

  // divide by the window length: multiply by the rounded-up reciprocal, drop the fraction
  assign a_prod = PROD_W'(a_sum) * PROD_W'(RECIP);
  assign r_prod = PROD_W'(r_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.divide) begin
      a_q <= a_prod[DIV_SHIFT +: MAG_W];
      r_q <= r_prod[DIV_SHIFT +: MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_baseline  <= '0;
      gyro_baseline <= '0;
      acc_margin    <= MARGIN_RESET;
      gyro_margin   <= MARGIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACC_BASELINE:  acc_baseline  <= wr_data;
        REG_GYRO_BASELINE: gyro_baseline <= wr_data;
        REG_ACC_MARGIN:    acc_margin    <= wr_data;
        REG_GYRO_MARGIN:   gyro_margin   <= wr_data;
        default: ;
      endcase
    end
  end

  assign acc_limit  = {1'b0, acc_baseline} + {1'b0, acc_margin};
  assign gyro_limit = {1'b0, gyro_baseline} + {1'b0, gyro_margin};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.moving     <= ({1'b0, a_q} > acc_limit) && ({1'b0, r_q} > gyro_limit);
      out_data.accel_mean <= a_q;
      out_data.rate_mean  <= r_q;
    end
  end

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import imd_pkg::*;

  localparam int WIN = 25;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 185;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7FFF;

  typedef enum int {SEG_STILL, SEG_SHAKE, SEG_EDGE} seg_kind_t;

  // Windowed magnitude predictor plus the queue of means still awaited.
  class motion_tracker;
    logic [15:0] acc_base, gyro_base, acc_marg, gyro_marg;
    logic [MAG_W-1:0] acc_hist[WIN];
    logic [MAG_W-1:0] gyro_hist[WIN];
    logic [20:0] acc_total, gyro_total;
    int slot;
    int errors;
    out_t awaited[$];

    function new();
      acc_base = '0;
      gyro_base = '0;
      acc_marg = MARGIN_RESET;
      gyro_marg = MARGIN_RESET;
      foreach (acc_hist[i]) begin
        acc_hist[i] = '0;
        gyro_hist[i] = '0;
      end
      acc_total = '0;
      gyro_total = '0;
      slot = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Largest r with r*r no greater than the sum of squares.
    function logic [MAG_W-1:0] magnitude(logic signed [AXIS_W-1:0] a,
                                         logic signed [AXIS_W-1:0] b,
                                         logic signed [AXIS_W-1:0] c);
      longint sq, lo, hi, mid;
      sq = longint'(a) * longint'(a) + longint'(b) * longint'(b) + longint'(c) * longint'(c);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= sq) lo = mid;
        else hi = mid - 1;
      end
      return MAG_W'(lo);
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [15:0] value);
      case (reg_idx_t'(idx))
        REG_ACC_BASELINE:  acc_base = value;
        REG_GYRO_BASELINE: gyro_base = value;
        REG_ACC_MARGIN:    acc_marg = value;
        REG_GYRO_MARGIN:   gyro_marg = value;
        default: ;
      endcase
    endfunction

    function void take_sample(in_t d);
      logic [MAG_W-1:0] am, gm;
      logic [16:0] acc_lim, gyro_lim;
      out_t want;
      am = magnitude(d.accel_x, d.accel_y, d.accel_z);
      gm = magnitude(d.rate_x, d.rate_y, d.rate_z);
      // replace the oldest entry of each window
      acc_total = acc_total - acc_hist[slot] + am;
      gyro_total = gyro_total - gyro_hist[slot] + gm;
      acc_hist[slot] = am;
      gyro_hist[slot] = gm;
      slot = (slot + 1) % WIN;
      want.accel_mean = MAG_W'(acc_total / WIN);
      want.rate_mean = MAG_W'(gyro_total / WIN);
      acc_lim = {1'b0, acc_base} + acc_marg;
      gyro_lim = {1'b0, gyro_base} + gyro_marg;
      want.moving = (want.accel_mean > acc_lim) && (want.rate_mean > gyro_lim);
      awaited.push_back(want);
    endfunction

    function void check_output(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $error("result with no request pending: moving %0b accel_mean %0d rate_mean %0d",
               got.moving, got.accel_mean, got.rate_mean);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.moving !== want.moving) begin
        $error("moving: expected %0b, got %0b", want.moving, got.moving);
        errors++;
      end
      if (got.accel_mean !== want.accel_mean) begin
        $error("accel_mean: expected %0d, got %0d", want.accel_mean, got.accel_mean);
        errors++;
      end
      if (got.rate_mean !== want.rate_mean) begin
        $error("rate_mean: expected %0d, got %0d", want.rate_mean, got.rate_mean);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [15:0] wr_data = '0;

  motion_tracker tracker = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;

  imu_motion_detector #(.WINDOW(WIN)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long enough to outlast a whole computation.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic seg_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return SEG_STILL;
    if (r < 88) return SEG_SHAKE;
    return SEG_EDGE;
  endfunction

  function automatic logic signed [AXIS_W-1:0] axis_value(seg_kind_t kind);
    case (kind)
      SEG_STILL: return AXIS_W'(int'($urandom_range(0, 4000)) - 2000);
      SEG_SHAKE: return AXIS_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return AXIS_MIN;
          1: return AXIS_MAX;
          2: return '0;
          3: return '1;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic in_t make_item(int ax, int ay, int az, int rx, int ry, int rz);
    in_t d;
    d.accel_x = AXIS_W'(ax);
    d.accel_y = AXIS_W'(ay);
    d.accel_z = AXIS_W'(az);
    d.rate_x = AXIS_W'(rx);
    d.rate_y = AXIS_W'(ry);
    d.rate_z = AXIS_W'(rz);
    return d;
  endfunction

  // Drop valid and hold until every awaited result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_request(in_t item, bit drain_first);
    int gap;
    gap = pick_gap();
    if (drain_first) wait_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_reg(logic [IDX_W-1:0] idx, logic [15:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [15:0] acc_base, logic [15:0] gyro_base,
                              logic [15:0] acc_marg, logic [15:0] gyro_marg,
                              bit poke_unused);
    put_reg(REG_ACC_BASELINE, acc_base);
    put_reg(REG_GYRO_BASELINE, gyro_base);
    put_reg(REG_ACC_MARGIN, acc_marg);
    put_reg(REG_GYRO_MARGIN, gyro_marg);
    if (poke_unused) begin
      for (int i = int'(REG_GYRO_MARGIN) + 1; i < (1 << IDX_W); i++)
        put_reg(IDX_W'(i), 16'($urandom));
    end
    wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_output(out_data);
      if (in_valid && !in_stall) tracker.take_sample(in_data);
      if (wr_en) tracker.set_register(wr_index, wr_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int stall_len;
    forever begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin
    seg_kind_t acc_kind, gyro_kind;
    int left;
    in_t item;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // warm-up from the zeroed windows under reset thresholds
    send_request(make_item(0, 0, 0, 0, 0, 0), 1'b0);
    send_request(make_item(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
    send_request(make_item(32767, 32767, 32767, -32768, -32768, -32768), 1'b0);
    send_request(make_item(-32768, 32767, 0, 0, -1, 1), 1'b0);
    send_request(make_item(0, 0, -32768, -32768, 0, 0), 1'b0);
    send_request(make_item(1, 1, 1, -1, -1, -1), 1'b0);
    send_request(make_item(3, 4, 0, 0, 5, 12), 1'b0);
    send_request(make_item(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
    send_request(make_item(21845, -21846, 21845, -21846, 21845, -21846), 1'b0);
    for (int i = 0; i < 6; i++)
      send_request(make_item(-32768, 32767, -32768, 10, -10, 5), 1'b0);
    for (int i = 0; i < 6; i++)
      send_request(make_item(0, 0, 0, 0, 0, 0), 1'b0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_config('0, '0, '0, '0, 1'b1);
        1: apply_config('1, '1, '1, '1, 1'b0);
        2: apply_config('0, '1, '0, 16'd100, 1'b1);
        default: apply_config(16'($urandom_range(0, 25000)), 16'($urandom_range(0, 25000)),
                              16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                              $urandom_range(0, 1));
      endcase
      quiet = (ph == 3 || ph == 6);
      left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (left == 0) begin
          left = $urandom_range(5, 40);
          acc_kind = pick_kind();
          gyro_kind = pick_kind();
        end
        left--;
        item.accel_x = axis_value(acc_kind);
        item.accel_y = axis_value(acc_kind);
        item.accel_z = axis_value(acc_kind);
        item.rate_x = axis_value(gyro_kind);
        item.rate_y = axis_value(gyro_kind);
        item.rate_z = axis_value(gyro_kind);
        send_request(item, $urandom_range(0, 49) == 0);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
